[hdl/md5md_pkg.sv]
// shared types, constants and round functions of the md5 digest block
`default_nettype none

package md5md_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last;
    } md5md_msg_t;

    typedef struct packed {
        logic [31:0] digest_word_a;
        logic [31:0] digest_word_b;
        logic [31:0] digest_word_c;
        logic [31:0] digest_word_d;
    } md5md_digest_t;

    localparam int unsigned BufWords  = 16;
    localparam int unsigned WordAddrW = 4;

    localparam logic [31:0] InitA = 32'h67452301;
    localparam logic [31:0] InitB = 32'hEFCDAB89;
    localparam logic [31:0] InitC = 32'h98BADCFE;
    localparam logic [31:0] InitD = 32'h10325476;

    localparam logic [7:0] PadByte = 8'h80;
    // word index of the length field in the final block
    localparam logic [WordAddrW-1:0] LenLoWord = 4'd14;
    localparam logic [WordAddrW-1:0] LenHiWord = 4'd15;
    localparam logic [WordAddrW-1:0] LastWord  = 4'd15;

    localparam logic [1:0] RndF = 2'd0;
    localparam logic [1:0] RndG = 2'd1;
    localparam logic [1:0] RndH = 2'd2;
    localparam logic [1:0] RndI = 2'd3;

    function automatic logic [31:0] round_const(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        logic [4:0] s;
        unique case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    // message word used by step i
    function automatic logic [WordAddrW-1:0] msg_index(input logic [5:0] i);
        logic [WordAddrW-1:0] n;
        logic [WordAddrW-1:0] g;
        n = i[WordAddrW-1:0];
        unique case (i[5:4])
            RndF: g = n;
            RndG: g = (n << 2) + n + 4'd1;
            RndH: g = (n << 1) + n + 4'd5;
            RndI: g = (n << 3) - n;
            default: g = n;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] round_fn(input logic [1:0] rnd, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        unique case (rnd)
            RndF: f = (b & c) | (~b & d);
            RndG: f = (b & d) | (c & ~d);
            RndH: f = b ^ c ^ d;
            RndI: f = c ^ (b | ~d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] t;
        t = {x, x} << s;
        return t[63:32];
    endfunction

endpackage

`default_nettype wire

[hdl/md5md_ram.sv]
// generic single-port-write, registered-read ram
`default_nettype none

module md5md_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hdl/md5_message_digest.sv]
// md5 digest of a byte stream: byte intake, padding and 64-step compression
//
// One beat carries one byte (or, with byte_present low and last high, just the end of a
// message). A byte that does not fill a 64-byte block is placed in the current word and busy stays
// low. A byte that fills a block starts a compression: a load state that primes the block buffer
// read, 64 rounds at one per cycle out of the 16-word buffer ram, and an add state that folds the
// result into the chaining words. A beat with last set writes the padding and length words
// (one word per cycle, from the current word up to word 15) and compresses once more, or
// twice when fewer than nine bytes of the block remain; the digest appears for one cycle with
// done high and must be captured then, as the block cannot be held off. It then starts over
// with a fresh message. Busy is high throughout.
`default_nettype none

module md5_message_digest
    import md5md_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire md5md_msg_t    msg,
    output logic               done,
    output md5md_digest_t      digest
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PAD  = 5'b00010,
        S_LOAD = 5'b00100,
        S_COMP = 5'b01000,
        S_ADD  = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [5:0]      step_reg, step_next;
    logic [3:0]      widx_reg, widx_next;
    logic            mark_reg, mark_next;   // next pad word carries the 0x80 byte
    logic            tail_reg, tail_next;   // this pad pass ends with the length
    logic            fin_reg, fin_next;     // this compression ends the message
    logic            pad_reg, pad_next;     // padding follows this compression
    logic [31:0]     word_reg, word_next;
    logic [63:0]     len_reg, len_next;
    logic [31:0]     h_reg [4];
    logic [31:0]     h_next [4];
    logic [31:0]     a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    md5md_digest_t   digest_reg, digest_next;
    logic            done_reg, done_next;

    logic                 ram_we;
    logic [WordAddrW-1:0] ram_waddr;
    logic [31:0]          ram_wdata;
    logic [WordAddrW-1:0] ram_raddr;
    logic [31:0]          ram_rdata;

    logic [1:0]  lane;
    logic [31:0] byte_word;
    logic [31:0] pad_word;
    logic [31:0] step_sum;
    logic [31:0] b_new;
    logic [5:0]  step_inc;

    md5md_ram #(
        .WIDTH (32),
        .DEPTH (BufWords)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign lane     = len_reg[4:3];
    assign step_inc = step_reg + 6'd1;

    // partial word with the new byte in its lane
    always_comb
    begin
        byte_word = word_reg;
        for (int k = 0; k < 4; k++)
        begin
            if (lane == k[1:0])
            begin
                byte_word[8*k +: 8] = msg.data_byte;
            end
        end
    end

    // pad word: bytes already taken, then 0x80, zeros, or a length half
    always_comb
    begin
        pad_word = 32'h0;
        if (mark_reg)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (k[1:0] < lane)
                begin
                    pad_word[8*k +: 8] = word_reg[8*k +: 8];
                end
                else if (k[1:0] == lane)
                begin
                    pad_word[8*k +: 8] = PadByte;
                end
            end
        end
        else if (tail_reg && widx_reg == LenLoWord)
        begin
            pad_word = len_reg[31:0];
        end
        else if (tail_reg && widx_reg == LenHiWord)
        begin
            pad_word = len_reg[63:32];
        end
    end

    assign step_sum = a_reg + round_fn(step_reg[5:4], b_reg, c_reg, d_reg)
                      + round_const(step_reg) + ram_rdata;
    assign b_new    = b_reg + rotl32(step_sum, rot_amount(step_reg));

    assign ram_raddr = (state_reg == S_LOAD) ? msg_index(step_reg) : msg_index(step_inc);

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        widx_next   = widx_reg;
        mark_next   = mark_reg;
        tail_next   = tail_reg;
        fin_next    = fin_reg;
        pad_next    = pad_reg;
        word_next   = word_reg;
        len_next    = len_reg;
        h_next      = h_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        d_next      = d_reg;
        digest_next = digest_reg;
        done_next   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = widx_reg;
        ram_wdata   = pad_word;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    widx_next = len_reg[8:5];
                    mark_next = 1'b1;
                    tail_next = (len_reg[8:6] != 3'b111);
                    if (msg.byte_present)
                    begin
                        word_next = byte_word;
                        len_next  = len_reg + 64'd8;
                        widx_next = len_next[8:5];
                        tail_next = (len_next[8:6] != 3'b111);
                        if (lane == 2'd3)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = len_reg[8:5];
                            ram_wdata = byte_word;
                        end
                        if (len_reg[8:3] == 6'd63)
                        begin
                            fin_next   = 1'b0;
                            pad_next   = msg.last;
                            step_next  = 6'd0;
                            state_next = S_LOAD;
                        end
                        else if (msg.last)
                        begin
                            state_next = S_PAD;
                        end
                    end
                    else if (msg.last)
                    begin
                        state_next = S_PAD;
                    end
                end
            end

            S_PAD:
            begin
                ram_we    = 1'b1;
                mark_next = 1'b0;
                widx_next = widx_reg + 4'd1;
                if (widx_reg == LastWord)
                begin
                    fin_next   = tail_reg;
                    pad_next   = !tail_reg;
                    tail_next  = 1'b1;
                    step_next  = 6'd0;
                    state_next = S_LOAD;
                end
            end

            S_LOAD:
            begin
                a_next     = h_reg[0];
                b_next     = h_reg[1];
                c_next     = h_reg[2];
                d_next     = h_reg[3];
                state_next = S_COMP;
            end

            S_COMP:
            begin
                a_next    = d_reg;
                b_next    = b_new;
                c_next    = b_reg;
                d_next    = c_reg;
                step_next = step_inc;
                if (step_reg == 6'd63)
                begin
                    state_next = S_ADD;
                end
            end

            S_ADD:
            begin
                h_next[0] = h_reg[0] + a_reg;
                h_next[1] = h_reg[1] + b_reg;
                h_next[2] = h_reg[2] + c_reg;
                h_next[3] = h_reg[3] + d_reg;
                widx_next = 4'd0;
                if (fin_reg)
                begin
                    digest_next.digest_word_a = h_next[0];
                    digest_next.digest_word_b = h_next[1];
                    digest_next.digest_word_c = h_next[2];
                    digest_next.digest_word_d = h_next[3];
                    done_next  = 1'b1;
                    h_next[0]  = InitA;
                    h_next[1]  = InitB;
                    h_next[2]  = InitC;
                    h_next[3]  = InitD;
                    len_next   = 64'd0;
                    state_next = S_IDLE;
                end
                else if (pad_reg)
                begin
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 6'd0;
            widx_reg  <= 4'd0;
            mark_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            pad_reg   <= 1'b0;
            len_reg   <= 64'd0;
            h_reg[0]  <= InitA;
            h_reg[1]  <= InitB;
            h_reg[2]  <= InitC;
            h_reg[3]  <= InitD;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            widx_reg  <= widx_next;
            mark_reg  <= mark_next;
            tail_reg  <= tail_next;
            fin_reg   <= fin_next;
            pad_reg   <= pad_next;
            len_reg   <= len_next;
            h_reg     <= h_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        digest_reg <= digest_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign digest = digest_reg;

endmodule

`default_nettype wire
